/* rtl/acas_pkg.sv */
// ----------------------------------------------------------------------------
// acas_pkg: shared types and constants for the chopped adc averaging scaler
// controller states, command and status bundles, register indexes
// ----------------------------------------------------------------------------
package acas_pkg;

  localparam int unsigned SamplesPerPhase = 10;
  localparam int unsigned CntW = $clog2(2 * SamplesPerPhase + 1);
  localparam int unsigned SumW = $clog2(SamplesPerPhase * 2048) + 1;
  localparam int unsigned DivW = 48;

  // phase average by reciprocal multiplication, exact over the sum range
  localparam int unsigned AvgShift = SumW - 1 + $clog2(SamplesPerPhase);
  localparam logic [SumW:0] AvgRecip =
    (SumW + 1)'((2 ** AvgShift + SamplesPerPhase - 1) / SamplesPerPhase);

  // register indexes
  localparam logic [2:0] RegGain   = 3'd0;
  localparam logic [2:0] RegNeg    = 3'd1;
  localparam logic [2:0] RegDivTop = 3'd2;
  localparam logic [2:0] RegDivBot = 3'd3;
  localparam logic [2:0] RegCurr   = 3'd4;
  localparam logic [2:0] RegRmode  = 3'd5;

  typedef enum logic [3:0] {
    StIdle,
    StDivA,
    StDivB,
    StCorr,
    StMv,
    StGain,
    StDivMul,
    StDivDiv,
    StSign,
    StOhmMul,
    StOhmDiv,
    StOut
  } state_e;

  // datapath operations started by the controller
  typedef enum logic [3:0] {
    OpNone,
    OpAccum,
    OpStartA,
    OpStartB,
    OpCorr,
    OpStartMv,
    OpStartGain,
    OpDivMul,
    OpStartDiv,
    OpSign,
    OpOhmMul,
    OpStartOhm,
    OpLoadOut
  } op_e;

  typedef struct packed {
    op_e  op;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_en;
    logic ohm_en;
    logic out_full;
  } status_t;

endpackage

/* rtl/acas_divider.sv */
// ----------------------------------------------------------------------------
// acas_divider: signed restoring divider, one quotient bit per cycle
// truncates toward zero
// ----------------------------------------------------------------------------
module acas_divider (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [acas_pkg::DivW-1:0] dividend_i,
  input  logic        [31:0]               divisor_i,
  output logic                             busy_o,
  output logic signed [acas_pkg::DivW-1:0] quot_o
);
  localparam int unsigned W = acas_pkg::DivW;

  logic [W-1:0]          q_q, q_d;
  logic [32:0]           rem_q, rem_d;
  logic [31:0]           dvs_q;
  logic                  neg_q;
  logic [$clog2(W+1)-1:0] cnt_q;
  logic [32:0]           trial;

  assign trial = {rem_q[31:0], q_q[W-1]} - {1'b0, dvs_q};
  always_comb begin
    q_d   = {q_q[W-2:0], 1'b0};
    rem_d = {rem_q[31:0], q_q[W-1]};
    if (!trial[32]) begin
      rem_d = trial;
      q_d[0] = 1'b1;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = neg_q ? -$signed(q_q) : $signed(q_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= ($clog2(W+1))'(W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i[W-1] ? W'(-dividend_i) : W'(dividend_i);
      neg_q <= dividend_i[W-1];
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_o) begin
      q_q   <= q_d;
      rem_q <= rem_d;
    end
  end
endmodule

/* rtl/acas_ctrl.sv */
// ----------------------------------------------------------------------------
// acas_ctrl: sequencer for accumulation and post processing
// ----------------------------------------------------------------------------
module acas_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  acas_pkg::status_t  status_i,
  output acas_pkg::cmd_t     cmd_o,
  output logic               busy_o
);
  acas_pkg::state_e state_q, state_d;
  logic [acas_pkg::CntW-1:0] cnt_q, cnt_d;
  logic acc;

  assign acc = (state_q == acas_pkg::StIdle) && in_valid;
  assign in_stall = (state_q != acas_pkg::StIdle);
  assign busy_o = (state_q != acas_pkg::StIdle);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o.op = acas_pkg::OpNone;
    cmd_o.last = 1'b0;
    case (state_q)
      acas_pkg::StIdle: begin
        if (in_valid) begin
          cmd_o.op = acas_pkg::OpAccum;
          cmd_o.last = (cnt_q >= acas_pkg::CntW'(acas_pkg::SamplesPerPhase));
          if (cnt_q == acas_pkg::CntW'(2 * acas_pkg::SamplesPerPhase - 1)) begin
            cnt_d = '0;
            state_d = acas_pkg::StDivA;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      acas_pkg::StDivA: begin
        cmd_o.op = acas_pkg::OpStartA;
        state_d = acas_pkg::StDivB;
      end
      acas_pkg::StDivB: begin
        if (!status_i.div_busy) begin
          cmd_o.op = acas_pkg::OpStartB;
          state_d = acas_pkg::StCorr;
        end
      end
      acas_pkg::StCorr: begin
        if (!status_i.div_busy) begin
          cmd_o.op = acas_pkg::OpCorr;
          state_d = acas_pkg::StMv;
        end
      end
      acas_pkg::StMv: begin
        cmd_o.op = acas_pkg::OpStartMv;
        state_d = acas_pkg::StGain;
      end
      acas_pkg::StGain: begin
        if (!status_i.div_busy) begin
          cmd_o.op = acas_pkg::OpStartGain;
          state_d = acas_pkg::StDivMul;
        end
      end
      acas_pkg::StDivMul: begin
        if (!status_i.div_busy) begin
          if (status_i.div_en) begin
            cmd_o.op = acas_pkg::OpDivMul;
            state_d = acas_pkg::StDivDiv;
          end else begin
            state_d = acas_pkg::StSign;
          end
        end
      end
      acas_pkg::StDivDiv: begin
        cmd_o.op = acas_pkg::OpStartDiv;
        state_d = acas_pkg::StSign;
      end
      acas_pkg::StSign: begin
        if (!status_i.div_busy) begin
          cmd_o.op = acas_pkg::OpSign;
          state_d = status_i.ohm_en ? acas_pkg::StOhmMul : acas_pkg::StOut;
        end
      end
      acas_pkg::StOhmMul: begin
        cmd_o.op = acas_pkg::OpOhmMul;
        state_d = acas_pkg::StOhmDiv;
      end
      acas_pkg::StOhmDiv: begin
        cmd_o.op = acas_pkg::OpStartOhm;
        state_d = acas_pkg::StOut;
      end
      acas_pkg::StOut: begin
        if (!status_i.div_busy && !status_i.out_full) begin
          cmd_o.op = acas_pkg::OpLoadOut;
          state_d = acas_pkg::StIdle;
        end
      end
      default: state_d = acas_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acas_pkg::StIdle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != acas_pkg::StIdle |-> !acc) else $error("accept while busy");
  cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < acas_pkg::CntW'(2 * acas_pkg::SamplesPerPhase)) else $error("count range");
  last_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && cnt_q == acas_pkg::CntW'(2 * acas_pkg::SamplesPerPhase - 1)
    |=> state_q == acas_pkg::StDivA) else $error("missed post processing");
endmodule

/* rtl/acas_datapath.sv */
// ----------------------------------------------------------------------------
// acas_datapath: accumulators, scaling registers, shared divider, output stage
// ----------------------------------------------------------------------------
module acas_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  acas_pkg::cmd_t      cmd_i,
  output acas_pkg::status_t   status_o,
  input  logic [11:0]         raw_code_i,
  input  logic [7:0]          gain_i,
  input  logic                neg_i,
  input  logic [19:0]         top_i,
  input  logic [19:0]         bot_i,
  input  logic [7:0]          curr_i,
  input  logic                rmode_i,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [11:0]  corrected_code_o,
  output logic signed [10:0]  adc_millivolts_o,
  output logic signed [23:0]  input_millivolts_o,
  output logic [31:0]         resistance_ohms_o,
  output logic                saturated_o
);
  localparam int unsigned W = acas_pkg::DivW;
  localparam int unsigned AvgPW = 2 * acas_pkg::SumW + 1;
  // round(up) of 1000 * 2^32 / 2047, exact for every corrected code
  localparam logic [30:0] MvRecip = 31'd2098176501;

  logic signed [acas_pkg::SumW-1:0] sum_a_q, sum_b_q, sum_sel;
  logic [acas_pkg::SumW-1:0] sum_mag;
  logic [AvgPW-1:0] avg_prod;
  logic [11:0] avg_mag, avg;
  logic signed [12:0] code;
  logic signed [11:0] a_q, b_q, corr_q;
  logic [10:0] corr_mag, mv_mag;
  logic [42:0] mv_prod;
  logic signed [10:0] mv_q, mv_val;
  logic signed [W-1:0] real_q;
  logic signed [W-1:0] div_dnd, div_q;
  logic signed [44:0] top_prod;
  logic [31:0] div_dvs;
  logic div_start, div_busy;
  logic signed [12:0] diff;
  logic signed [W-1:0] mag;
  logic ohm_sat, mv_sat;
  logic signed [23:0] mv_clip;

  assign code = $signed({1'b0, raw_code_i}) - 13'sd2048;
  assign diff = 13'(a_q) - 13'(b_q);
  assign mag = real_q[W-1] ? -real_q : real_q;

  // phase average, truncated toward zero
  assign sum_sel = (cmd_i.op == acas_pkg::OpStartB) ? sum_b_q : sum_a_q;
  assign sum_mag = sum_sel[acas_pkg::SumW-1] ? -sum_sel : sum_sel;
  assign avg_prod = AvgPW'(sum_mag) * AvgPW'(acas_pkg::AvgRecip);
  assign avg_mag = 12'(avg_prod >> acas_pkg::AvgShift);
  assign avg = sum_sel[acas_pkg::SumW-1] ? -avg_mag : avg_mag;

  // corrected code to millivolts, truncated toward zero
  assign corr_mag = corr_q[11] ? 11'(-corr_q) : 11'(corr_q);
  assign mv_prod = 43'(corr_mag) * 43'(MvRecip);
  assign mv_mag = mv_prod[42:32];
  assign mv_val = corr_q[11] ? -mv_mag : mv_mag;

  assign top_prod = $signed(real_q[23:0]) * $signed({1'b0, top_i});

  always_comb begin
    div_start = 1'b0;
    div_dnd = '0;
    div_dvs = 32'd1;
    case (cmd_i.op)
      acas_pkg::OpStartGain: begin
        div_start = 1'b1;
        div_dnd = W'(mv_q) * W'(100);
        div_dvs = (gain_i == '0) ? 32'd1 : 32'(gain_i);
      end
      acas_pkg::OpStartDiv: begin
        div_start = 1'b1;
        div_dnd = W'(top_prod);
        div_dvs = 32'(bot_i);
      end
      acas_pkg::OpStartOhm: begin
        div_start = 1'b1;
        // times 1000 as 1024 - 16 - 8
        div_dnd = (mag <<< 10) - (mag <<< 4) - (mag <<< 3);
        div_dvs = 32'(curr_i);
      end
      default: ;
    endcase
  end

  acas_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dnd),
    .divisor_i(div_dvs), .busy_o(div_busy), .quot_o(div_q)
  );

  assign status_o.div_busy = div_busy;
  assign status_o.div_en = (top_i != '0) && (bot_i != '0);
  assign status_o.ohm_en = rmode_i && (curr_i != '0);
  assign status_o.out_full = out_valid && out_stall;

  // resistance quotient still sits in the divider at load time
  assign ohm_sat = status_o.ohm_en && (div_q > W'(64'hFFFF_FFFF));
  assign mv_sat = (real_q > W'(8388607)) || (real_q < -W'(8388608));
  assign mv_clip = (real_q > W'(8388607)) ? 24'sh7FFFFF :
                   (real_q < -W'(8388608)) ? -24'sh800000 : real_q[23:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q <= '0;
      sum_b_q <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_i.op == acas_pkg::OpAccum) begin
        if (cmd_i.last) sum_b_q <= sum_b_q + acas_pkg::SumW'(code);
        else            sum_a_q <= sum_a_q + acas_pkg::SumW'(code);
      end
      if (cmd_i.op == acas_pkg::OpStartB) begin
        sum_a_q <= '0;
        sum_b_q <= '0;
      end
      if (cmd_i.op == acas_pkg::OpLoadOut) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      acas_pkg::OpStartA: a_q <= avg;
      acas_pkg::OpStartB: b_q <= avg;
      acas_pkg::OpCorr: corr_q <= 12'(diff / 13'sd2);
      acas_pkg::OpStartMv: mv_q <= mv_val;
      acas_pkg::OpDivMul: real_q <= div_q;
      acas_pkg::OpSign: begin
        if (status_o.div_en) real_q <= neg_i ? -(real_q + div_q) : real_q + div_q;
        else real_q <= neg_i ? -div_q : div_q;
      end
      acas_pkg::OpLoadOut: begin
        corrected_code_o <= corr_q;
        adc_millivolts_o <= mv_q;
        input_millivolts_o <= mv_clip;
        resistance_ohms_o <= ohm_sat ? 32'hFFFF_FFFF :
                             (status_o.ohm_en ? div_q[31:0] : '0);
        saturated_o <= mv_sat || ohm_sat;
      end
      default: ;
    endcase
  end
endmodule

/* rtl/adc_chopped_average_scaler_unit.sv */
// ----------------------------------------------------------------------------
// adc_chopped_average_scaler_unit: chopper offset cancelling adc averager
// ----------------------------------------------------------------------------
// Twenty raw codes form one measurement, one request per cycle while idle.
// After the twentieth code the input stalls during post processing: phase
// averages, correction and millivolt scaling use reciprocal multiplication,
// then the shared one-bit-per-cycle 48 bit divider runs up to three times
// (gain, input divider, resistance), and the result register loads once the
// divider is idle and no previous result is still stalled. Register writes
// are taken only while no measurement is being post processed.
module adc_chopped_average_scaler_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        raw_code_i,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index_i,
  input  logic [19:0]        cfg_data_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [11:0] corrected_code_o,
  output logic signed [10:0] adc_millivolts_o,
  output logic signed [23:0] input_millivolts_o,
  output logic [31:0]        resistance_ohms_o,
  output logic               saturated_o
);
  acas_pkg::cmd_t    cmd;
  acas_pkg::status_t status;
  logic busy;
  logic [7:0] gain_q, curr_q;
  logic neg_q, rmode_q;
  logic [19:0] top_q, bot_q;

  // registers stay fixed while a measurement is post processed
  assign cfg_ready = !busy;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 8'd100;
      neg_q <= 1'b0;
      top_q <= '0;
      bot_q <= '0;
      curr_q <= '0;
      rmode_q <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_i)
        acas_pkg::RegGain:   gain_q <= cfg_data_i[7:0];
        acas_pkg::RegNeg:    neg_q <= cfg_data_i[0];
        acas_pkg::RegDivTop: top_q <= cfg_data_i;
        acas_pkg::RegDivBot: bot_q <= cfg_data_i;
        acas_pkg::RegCurr:   curr_q <= cfg_data_i[7:0];
        acas_pkg::RegRmode:  rmode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  acas_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .status_i(status), .cmd_o(cmd),
    .busy_o(busy)
  );

  acas_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .raw_code_i,
    .gain_i(gain_q), .neg_i(neg_q), .top_i(top_q), .bot_i(bot_q),
    .curr_i(curr_q), .rmode_i(rmode_q), .out_valid, .out_stall,
    .corrected_code_o, .adc_millivolts_o, .input_millivolts_o,
    .resistance_ohms_o, .saturated_o
  );
endmodule
